FILE: design/cdpr_pkg.sv
// ----------------------------------------------------------------------------
// cdpr_pkg - shared types and constants for the channel delay phase rotator
// Payload structs, register indexes and the elaboration-time trig table
// generator (first quadrant, Taylor series in Q30).
// ----------------------------------------------------------------------------
package cdpr_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int CHANNEL_BITS = 13;
  localparam int PHASE_BITS   = 32;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 1;

  // pi in Q48, and one in Q30
  localparam logic [63:0] PI_Q48  = 64'h0003_243F_6A88_85A3;
  localparam longint      Q30_ONE = 64'sd1 <<< 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_CHANNEL     = 1'b0,
    CFG_PHASE_PER_CHANNEL = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic [CHANNEL_BITS-1:0]       channel_index;
    logic                          is_autocorrelation;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] rotated_re;
    logic signed [SAMPLE_BITS-1:0] rotated_im;
    logic                          sample_flagged;
  } result_t;

  // sample sideband carried down the pipeline
  typedef struct packed {
    logic                          missing;
    logic                          autoc;
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
  } side_t;

  localparam logic signed [SAMPLE_BITS-1:0] MISSING_CODE =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Q30 value -> Q1.(trig_bits-1), clamped to [0, 2^30], round half up
  function automatic longint to_trig(input longint v, input int trig_bits);
    longint lim;
    longint w;
    longint e;
    lim = (64'sd1 <<< (trig_bits - 1)) - 64'sd1;
    w   = v;
    if (w < 0) w = 0;
    if (w > Q30_ONE) w = Q30_ONE;
    e = (w + (64'sd1 <<< (30 - trig_bits))) >>> (31 - trig_bits);
    return (e > lim) ? lim : e;
  endfunction

  // First-quadrant entry r: cos in [63:32], sin in [31:0]
  function automatic logic [63:0] trig_entry(input int unsigned r, input int lut_bits,
                                             input int trig_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint      s;
    longint      c;
    longint      cv;
    longint      sv;
    x  = (PI_Q48 * 64'(r)) >> (lut_bits - 1 + 18);
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'(Q30_ONE);
    s  = longint'(x);
    c  = Q30_ONE;
    for (int k = 1; k <= 8; k++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
    cv = to_trig(c, trig_bits);
    sv = to_trig(s, trig_bits);
    return {32'(cv), 32'(sv)};
  endfunction

endpackage

FILE: design/channel_delay_phase_rotator.sv
// ----------------------------------------------------------------------------
// channel_delay_phase_rotator - per-channel delay phase rotation of visibilities
// Rotates cross-correlation samples by (first_channel+index)*phase_per_channel
// turns through a cos/sin table; autocorrelations pass, missing codes flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive sample_i and raise start; a transfer happens on each rising
//   edge with start high and busy low. busy is held low, so one sample
//   can be taken every cycle, back to back, for as long as the source has one.
//   Output: each sample yields one result on result_o, shown for exactly one
//   cycle with result_valid_o high. The receiver cannot stall; results come
//   in input order.
//   Registers from input to result: chan_q, addr_q, rom_q, cos_q/sin_q, the
//   products, result_q. Throughput one sample per cycle: every stage and the
//   table read are registered and nothing in the pipeline holds a sample back.
//   Config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 first_channel,
//   1 phase_per_channel). Write only while no sample is in flight.
//   Reset: rst_ni clears both registers and drops every pipeline valid bit;
//   items in flight are dropped. No table clearing is needed, the table is ROM.
// ----------------------------------------------------------------------------
module channel_delay_phase_rotator #(
  parameter int PHASE_LUT_BITS = 10,
  parameter int TRIG_BITS      = 18
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  cdpr_pkg::sample_t                sample_i,
  output logic                             result_valid_o,
  output cdpr_pkg::result_t                result_o,
  input  logic                             cfg_we_i,
  input  logic [cdpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cdpr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int SW       = cdpr_pkg::SAMPLE_BITS;
  localparam int CW       = cdpr_pkg::CHANNEL_BITS;
  localparam int CH_SUM_W = CW + 1;
  localparam int PHW      = cdpr_pkg::PHASE_BITS;
  localparam int QA       = PHASE_LUT_BITS - 2;
  localparam int QDEPTH   = 1 << QA;
  localparam int PW       = SW + TRIG_BITS;     // one product
  localparam int ACC_W    = PW + 1;             // sum of two products
  localparam int RW       = ACC_W - (TRIG_BITS - 1);
  localparam int STAGES   = 6;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (TRIG_BITS - 2);
  localparam logic signed [RW-1:0]    SAT_POS  = RW'((1 << (SW - 1)) - 1);
  localparam logic signed [RW-1:0]    SAT_NEG  = -SAT_POS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0]  first_channel_q;
  logic [PHW-1:0] phase_per_channel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_channel_q     <= '0;
      phase_per_channel_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cdpr_pkg::cfg_idx_e'(cfg_idx_i))
        cdpr_pkg::CFG_FIRST_CHANNEL:     first_channel_q     <= cfg_data_i[CW-1:0];
        cdpr_pkg::CFG_PHASE_PER_CHANNEL: phase_per_channel_q <= cfg_data_i[PHW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so the block always takes a transfer.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Valid bits and sideband shift line (stage 1 .. 5 sideband)
  // --------------------------------------------------------------------------
  logic [STAGES-1:0] valid_q;
  cdpr_pkg::side_t   side_q [STAGES-1];
  cdpr_pkg::side_t   side_d;

  always_comb begin
    side_d.re      = sample_i.sample_re;
    side_d.im      = sample_i.sample_im;
    side_d.autoc   = sample_i.is_autocorrelation;
    side_d.missing = (sample_i.sample_re == cdpr_pkg::MISSING_CODE) ||
                     (sample_i.sample_im == cdpr_pkg::MISSING_CODE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < STAGES - 1; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: absolute channel number (no wrap)
  // --------------------------------------------------------------------------
  logic [CH_SUM_W-1:0] chan_q;

  always_ff @(posedge clk_i) begin
    chan_q <= CH_SUM_W'(first_channel_q) + CH_SUM_W'(sample_i.channel_index);
  end

  // --------------------------------------------------------------------------
  // Stage 2: phase = chan * step mod 2^32; keep the top table bits
  // --------------------------------------------------------------------------
  logic [PHW-1:0]            phase;
  logic [PHASE_LUT_BITS-1:0] addr_q;

  assign phase = PHW'(PHW'(chan_q) * phase_per_channel_q);

  always_ff @(posedge clk_i) begin
    addr_q <= phase[PHW-1 -: PHASE_LUT_BITS];
  end

  // --------------------------------------------------------------------------
  // Stage 3: first-quadrant cos/sin ROM, registered read
  // --------------------------------------------------------------------------
  logic [2*TRIG_BITS-1:0] trig_rom [QDEPTH];
  logic [2*TRIG_BITS-1:0] rom_q;
  logic [1:0]             quad_q;

  for (genvar a = 0; a < QDEPTH; a++) begin : g_rom
    localparam logic [63:0] Entry =
      cdpr_pkg::trig_entry(a, PHASE_LUT_BITS, TRIG_BITS);
    assign trig_rom[a] = {Entry[32 +: TRIG_BITS], Entry[0 +: TRIG_BITS]};
  end

  always_ff @(posedge clk_i) begin
    rom_q  <= trig_rom[addr_q[QA-1:0]];
    quad_q <= addr_q[PHASE_LUT_BITS-1 -: 2];
  end

  // --------------------------------------------------------------------------
  // Stage 4: quadrant mapping
  // --------------------------------------------------------------------------
  logic signed [TRIG_BITS-1:0] rom_cos, rom_sin;
  logic signed [TRIG_BITS-1:0] cos_q, sin_q;

  assign rom_cos = $signed(rom_q[2*TRIG_BITS-1 -: TRIG_BITS]);
  assign rom_sin = $signed(rom_q[TRIG_BITS-1:0]);

  always_ff @(posedge clk_i) begin
    unique case (quad_q)
      2'd0: begin cos_q <= rom_cos;  sin_q <= rom_sin;  end
      2'd1: begin cos_q <= -rom_sin; sin_q <= rom_cos;  end
      2'd2: begin cos_q <= -rom_cos; sin_q <= -rom_sin; end
      default: begin cos_q <= rom_sin; sin_q <= -rom_cos; end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 5: four products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] re_cos_q, im_sin_q, re_sin_q, im_cos_q;
  logic signed [PW-1:0] s_re, s_im;

  assign s_re = PW'($signed(side_q[3].re));
  assign s_im = PW'($signed(side_q[3].im));

  always_ff @(posedge clk_i) begin
    re_cos_q <= s_re * PW'(cos_q);
    im_sin_q <= s_im * PW'(sin_q);
    re_sin_q <= s_re * PW'(sin_q);
    im_cos_q <= s_im * PW'(cos_q);
  end

  // --------------------------------------------------------------------------
  // Stage 6: sum, round half up, saturate symmetric; special cases
  // --------------------------------------------------------------------------
  function automatic logic signed [SW-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] shifted;
    logic signed [RW-1:0]    q;
    shifted = (acc + RND_HALF) >>> (TRIG_BITS - 1);
    q       = shifted[RW-1:0];
    if (q > SAT_POS) q = SAT_POS;
    if (q < SAT_NEG) q = SAT_NEG;
    return q[SW-1:0];
  endfunction

  logic signed [ACC_W-1:0] acc_re, acc_im;
  cdpr_pkg::result_t       result_d, result_q;

  assign acc_re = ACC_W'(re_cos_q) - ACC_W'(im_sin_q);
  assign acc_im = ACC_W'(re_sin_q) + ACC_W'(im_cos_q);

  always_comb begin
    priority if (side_q[4].missing) begin
      result_d.rotated_re     = '0;
      result_d.rotated_im     = '0;
      result_d.sample_flagged = 1'b1;
    end else if (side_q[4].autoc) begin
      result_d.rotated_re     = side_q[4].re;
      result_d.rotated_im     = side_q[4].im;
      result_d.sample_flagged = 1'b0;
    end else begin
      result_d.rotated_re     = round_sat(acc_re);
      result_d.rotated_im     = round_sat(acc_im);
      result_d.sample_flagged = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o       = result_q;
  assign result_valid_o = valid_q[STAGES-1];

endmodule
